// ----- rtl/njdr_pkg.sv -----
// Package for the nearest-jet delta-R matcher.
// Field widths, register map codes and shared types; no dependencies.
package njdr_pkg;

    localparam int ETA_W     = 12;
    localparam int PHI_W     = 11;
    localparam int DIST_W    = 30;
    localparam int POS_W     = 10;
    localparam int REF_NUM_W = 2;
    localparam int NUM_REFS  = 3;
    // eta difference squared stays below 2^24, phi difference squared below 2^22
    localparam int SQ_W      = 25;
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;

    localparam logic [DIST_W-1:0] LIMIT_RESET = 30'd642318336;

    typedef logic signed [ETA_W-1:0] t_eta;
    typedef logic signed [PHI_W-1:0] t_phi;
    typedef logic [DIST_W-1:0]       t_dist;
    typedef logic [POS_W-1:0]        t_pos;

    typedef enum logic [2:0] {
        REG_REF1_ETA  = 3'd0,
        REG_REF1_PHI  = 3'd1,
        REG_REF2_ETA  = 3'd2,
        REG_REF2_PHI  = 3'd3,
        REG_REF3_ETA  = 3'd4,
        REG_REF3_PHI  = 3'd5,
        REG_REF3_EN   = 3'd6,
        REG_MAX_DIST  = 3'd7
    } t_reg_idx;

endpackage

// ----- rtl/njdr_jet_if.sv -----
// Jet input channel: valid/ready handshake carrying one jet per transaction.
// Depends on njdr_pkg.
interface njdr_jet_if import njdr_pkg::*; ();
    logic valid;
    logic ready;
    t_eta jet_eta;
    t_phi jet_phi;
    logic last_jet;

    modport source (output valid, jet_eta, jet_phi, last_jet, input ready);
    modport sink   (input valid, jet_eta, jet_phi, last_jet, output ready);
endinterface

// ----- rtl/njdr_res_if.sv -----
// Result output channel: valid/ready handshake carrying one match result.
// Depends on njdr_pkg.
interface njdr_res_if import njdr_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [REF_NUM_W-1:0] reference_number;
    logic                 matched;
    t_pos                 jet_position;
    t_dist                distance_sq;
    logic                 last_result;

    modport source (output valid, reference_number, matched, jet_position,
                    distance_sq, last_result, input ready);
    modport sink   (input valid, reference_number, matched, jet_position,
                    distance_sq, last_result, output ready);
endinterface

// ----- rtl/nearest_jet_delta_r_matcher_unit.sv -----
// Top level of the nearest-jet delta-R matcher.
// Depends on njdr_pkg, njdr_jet_if and njdr_res_if.
//
// Usage:
//   i_jet carries one jet per transaction (eta, phi, last_jet flag). For each
//   of three reference directions the block keeps the earliest jet with the
//   strictly smallest squared eta-phi distance below max_distance_sq.
//   After the jet flagged last_jet, o_res delivers three transactions, one per
//   reference in order 0, 1, 2, the third with last_result set.
//   The APB port holds the references, the third-reference enable and the
//   squared distance limit; write it only while no event is in flight.
// Timing:
//   Stage one registers the three squared distances of an accepted jet; stage
//   two compares them against the running best and updates the event state.
//   One jet is accepted every cycle unless a flagged jet is waiting (below).
//   The first result of an event is valid the cycle after the flagged jet
//   leaves stage one; the three results then leave one per cycle, while
//   o_res is ready, from a result buffer.
//   The buffer holds one event, so a flagged jet that reaches stage two while
//   the previous event's results are still draining waits there, and i_jet
//   stalls behind it. A stalled receiver only delays further flagged jets.
// Reset: synchronous active-low i_rst_n clears configuration to its defaults,
//   empties both stages and the result buffer, and clears the event state.
module nearest_jet_delta_r_matcher_unit
    import njdr_pkg::*;
#(
    parameter int MAX_JETS = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    njdr_jet_if.sink          i_jet,
    njdr_res_if.source        o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int CNT_W = $clog2(MAX_JETS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_JETS);

    // configuration
    t_eta        r_ref_eta [NUM_REFS];
    t_phi        r_ref_phi [NUM_REFS];
    logic        r_ref3_en;
    t_dist       r_max_dist;

    // stage one: distances of the accepted jet
    logic        r_s_valid;
    logic        r_s_last;
    t_dist       r_s_dist [NUM_REFS];

    // event state
    logic [NUM_REFS-1:0] r_found;
    t_pos        r_pos  [NUM_REFS];
    t_dist       r_dist [NUM_REFS];
    logic [CNT_W-1:0] r_cnt;

    // result buffer
    logic        r_ob_valid;
    logic [REF_NUM_W-1:0] r_idx;
    logic [NUM_REFS-1:0] r_ob_found;
    t_pos        r_ob_pos  [NUM_REFS];
    t_dist       r_ob_dist [NUM_REFS];

    logic        cfg_wr;
    t_reg_idx    cfg_idx;
    logic        out_take;
    logic        buf_free;
    logic        s_take;
    logic        in_ready;
    logic        cnt_ok;
    t_dist       n_s_dist [NUM_REFS];
    logic [NUM_REFS-1:0] n_found;
    t_pos        n_pos  [NUM_REFS];
    t_dist       n_dist [NUM_REFS];

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[APB_AW-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < NUM_REFS; r++) begin
                r_ref_eta[r] <= '0;
                r_ref_phi[r] <= '0;
            end
            r_ref3_en  <= 1'b0;
            r_max_dist <= LIMIT_RESET;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_REF1_ETA: r_ref_eta[0] <= pwdata[ETA_W-1:0];
                REG_REF1_PHI: r_ref_phi[0] <= pwdata[PHI_W-1:0];
                REG_REF2_ETA: r_ref_eta[1] <= pwdata[ETA_W-1:0];
                REG_REF2_PHI: r_ref_phi[1] <= pwdata[PHI_W-1:0];
                REG_REF3_ETA: r_ref_eta[2] <= pwdata[ETA_W-1:0];
                REG_REF3_PHI: r_ref_phi[2] <= pwdata[PHI_W-1:0];
                REG_REF3_EN:  r_ref3_en    <= pwdata[0];
                REG_MAX_DIST: r_max_dist   <= pwdata[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_REF1_ETA: prdata = APB_DW'($unsigned(r_ref_eta[0]));
            REG_REF1_PHI: prdata = APB_DW'($unsigned(r_ref_phi[0]));
            REG_REF2_ETA: prdata = APB_DW'($unsigned(r_ref_eta[1]));
            REG_REF2_PHI: prdata = APB_DW'($unsigned(r_ref_phi[1]));
            REG_REF3_ETA: prdata = APB_DW'($unsigned(r_ref_eta[2]));
            REG_REF3_PHI: prdata = APB_DW'($unsigned(r_ref_phi[2]));
            REG_REF3_EN:  prdata = APB_DW'(r_ref3_en);
            REG_MAX_DIST: prdata = APB_DW'(r_max_dist);
            default:      prdata = '0;
        endcase
    end

    // ---------------- handshakes ----------------
    assign out_take    = r_ob_valid && o_res.ready;
    assign buf_free    = !r_ob_valid || (out_take && (r_idx == REF_NUM_W'(NUM_REFS - 1)));
    assign s_take      = r_s_valid && (!r_s_last || buf_free);
    assign in_ready    = !r_s_valid || s_take;
    assign i_jet.ready = in_ready;

    // ---------------- stage one: squared distances ----------------
    always_comb begin
        logic signed [ETA_W:0]     de;
        logic signed [PHI_W:0]     dp;
        logic signed [2*ETA_W+1:0] de_sq;
        logic signed [2*PHI_W+1:0] dp_sq;
        logic [SQ_W-1:0]           sum;
        de    = '0;
        dp    = '0;
        de_sq = '0;
        dp_sq = '0;
        sum   = '0;
        for (int r = 0; r < NUM_REFS; r++) begin
            de    = (ETA_W+1)'(r_ref_eta[r]) - (ETA_W+1)'(i_jet.jet_eta);
            dp    = (PHI_W+1)'(r_ref_phi[r]) - (PHI_W+1)'(i_jet.jet_phi);
            de_sq = de * de;
            dp_sq = dp * dp;
            sum   = SQ_W'(de_sq[2*ETA_W-1:0]) + SQ_W'(dp_sq[2*PHI_W-1:0]);
            n_s_dist[r] = DIST_W'(sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
        end else if (in_ready) begin
            r_s_valid <= i_jet.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_jet.valid) begin
            r_s_last <= i_jet.last_jet;
            for (int r = 0; r < NUM_REFS; r++) begin
                r_s_dist[r] <= n_s_dist[r];
            end
        end
    end

    // ---------------- stage two: compare and update ----------------
    assign cnt_ok = (r_cnt < CNT_MAX);

    always_comb begin
        logic  en;
        logic  hit;
        t_dist bound;
        en    = 1'b0;
        hit   = 1'b0;
        bound = '0;
        for (int r = 0; r < NUM_REFS; r++) begin
            en    = cnt_ok && ((r != NUM_REFS - 1) || r_ref3_en);
            bound = r_found[r] ? r_dist[r] : r_max_dist;
            hit   = en && (r_s_dist[r] < bound);
            n_found[r] = r_found[r] || hit;
            n_pos[r]   = hit ? POS_W'(r_cnt) : r_pos[r];
            n_dist[r]  = hit ? r_s_dist[r] : r_dist[r];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= '0;
            r_cnt   <= '0;
        end else if (s_take) begin
            if (r_s_last) begin
                // event closed: clear for the next one
                r_found <= '0;
                r_cnt   <= '0;
            end else begin
                r_found <= n_found;
                if (cnt_ok) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_take) begin
            for (int r = 0; r < NUM_REFS; r++) begin
                r_pos[r]  <= n_pos[r];
                r_dist[r] <= n_dist[r];
            end
        end
    end

    // ---------------- result buffer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob_valid <= 1'b0;
            r_idx      <= '0;
        end else if (s_take && r_s_last) begin
            r_ob_valid <= 1'b1;
            r_idx      <= '0;
        end else if (out_take) begin
            if (r_idx == REF_NUM_W'(NUM_REFS - 1)) begin
                r_ob_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_take && r_s_last) begin
            r_ob_found <= n_found;
            for (int r = 0; r < NUM_REFS; r++) begin
                r_ob_pos[r]  <= n_found[r] ? n_pos[r] : '0;
                r_ob_dist[r] <= n_found[r] ? n_dist[r] : '0;
            end
        end
    end

    assign o_res.valid            = r_ob_valid;
    assign o_res.reference_number = r_idx;
    assign o_res.last_result      = (r_idx == REF_NUM_W'(NUM_REFS - 1));

    always_comb begin
        case (r_idx)
            2'd0: begin
                o_res.matched      = r_ob_found[0];
                o_res.jet_position = r_ob_pos[0];
                o_res.distance_sq  = r_ob_dist[0];
            end
            2'd1: begin
                o_res.matched      = r_ob_found[1];
                o_res.jet_position = r_ob_pos[1];
                o_res.distance_sq  = r_ob_dist[1];
            end
            2'd2: begin
                o_res.matched      = r_ob_found[2];
                o_res.jet_position = r_ob_pos[2];
                o_res.distance_sq  = r_ob_dist[2];
            end
            default: begin
                o_res.matched      = 1'b0;
                o_res.jet_position = '0;
                o_res.distance_sq  = '0;
            end
        endcase
    end

endmodule

// ----- bench/nearest_jet_delta_r_matcher_unit_tb.sv -----
// Self-checking bench for nearest_jet_delta_r_matcher_unit: jet stream in, match results out.
// Depends on njdr_pkg, njdr_jet_if, njdr_res_if and the matcher RTL.
// An in-bench predictor computes the expected matches as each jet is accepted.
module nearest_jet_delta_r_matcher_unit_tb import njdr_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_JETS     = 1024;
    localparam int ETA_LIM      = 1280;
    localparam int PHI_LIM      = 805;
    localparam int SEND_GAP_MAX = 8;
    localparam int STALL_MAX    = 6;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 42;

    typedef struct {
        t_eta eta;
        t_phi phi;
        logic last_jet;
        logic hold;
    } t_jet_item;

    typedef struct {
        logic [REF_NUM_W-1:0] ref_num;
        logic                 matched;
        t_pos                 pos;
        t_dist                distance;
        logic                 last_res;
    } t_match_res;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    njdr_jet_if jet_if ();
    njdr_res_if res_if ();

    nearest_jet_delta_r_matcher_unit #(
        .MAX_JETS(MAX_JETS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_jet   (jet_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // stimulus and expectations
    t_jet_item  pending_jets[$];
    t_match_res expected_matches[$];
    t_jet_item  current_jet;
    int         jets_outstanding;

    // predictor copy of configuration and event state
    t_eta  ref_eta_cfg[NUM_REFS];
    t_phi  ref_phi_cfg[NUM_REFS];
    logic  ref3_en_cfg;
    t_dist limit_cfg;
    t_dist best_dist[NUM_REFS];
    t_pos  best_pos[NUM_REFS];
    logic  found[NUM_REFS];
    int    jet_index;

    // idling control
    bit sender_bursty;
    bit receiver_stalls;
    int burst_left;
    int gap_left;
    int ready_run;
    int stall_run;

    int cycle_count;
    int mismatches;
    int jets_accepted;
    int events_queued;
    int results_checked;
    int reg_writes;

    function automatic int rand_between(input int lo, input int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic int clamp(input int v, input int lim);
        return (v > lim) ? lim : (v < -lim) ? -lim : v;
    endfunction

    function automatic void clear_event();
        for (int r = 0; r < NUM_REFS; r++) begin
            best_dist[r] = limit_cfg;
            best_pos[r]  = '0;
            found[r]     = 1'b0;
        end
        jet_index = 0;
    endfunction

    // Update the running nearest jet per reference; emit three results on the last jet.
    function automatic void predict_matches(input t_jet_item jet);
        int         d_eta;
        int         d_phi;
        t_dist      dsq;
        t_dist      bound;
        t_match_res res;
        if (jet_index < MAX_JETS) begin
            for (int r = 0; r < NUM_REFS; r++) begin
                if (r == NUM_REFS - 1 && !ref3_en_cfg) continue;
                d_eta = int'(ref_eta_cfg[r]) - int'(jet.eta);
                d_phi = int'(ref_phi_cfg[r]) - int'(jet.phi);
                dsq   = t_dist'(d_eta * d_eta + d_phi * d_phi);
                bound = found[r] ? best_dist[r] : limit_cfg;
                if (dsq < bound) begin
                    best_dist[r] = dsq;
                    best_pos[r]  = t_pos'(jet_index);
                    found[r]     = 1'b1;
                end
            end
            jet_index++;
        end
        if (jet.last_jet) begin
            for (int r = 0; r < NUM_REFS; r++) begin
                res.ref_num  = REF_NUM_W'(r);
                res.matched  = found[r];
                res.pos      = found[r] ? best_pos[r] : '0;
                res.distance = found[r] ? best_dist[r] : '0;
                res.last_res = (r == NUM_REFS - 1);
                expected_matches = {expected_matches, res};
            end
            clear_event();
        end
    endfunction

    function automatic void check_field(input string field, input logic [DIST_W-1:0] expv,
                                        input logic [DIST_W-1:0] actual);
        if (actual !== expv) begin
            mismatches++;
            $error("%s: expected %0d, got %0d", field, expv, actual);
        end
    endfunction

    task automatic write_reg(input t_reg_idx idx, input logic [APB_DW-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(idx) << 2;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_REF1_ETA: ref_eta_cfg[0] = value[ETA_W-1:0];
            REG_REF1_PHI: ref_phi_cfg[0] = value[PHI_W-1:0];
            REG_REF2_ETA: ref_eta_cfg[1] = value[ETA_W-1:0];
            REG_REF2_PHI: ref_phi_cfg[1] = value[PHI_W-1:0];
            REG_REF3_ETA: ref_eta_cfg[2] = value[ETA_W-1:0];
            REG_REF3_PHI: ref_phi_cfg[2] = value[PHI_W-1:0];
            REG_REF3_EN:  ref3_en_cfg    = value[0];
            REG_MAX_DIST: limit_cfg      = value[DIST_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic load_config(input int e1, input int p1, input int e2, input int p2,
                               input int e3, input int p3, input bit en, input t_dist lim);
        write_reg(REG_REF1_ETA, APB_DW'(e1));
        write_reg(REG_REF1_PHI, APB_DW'(p1));
        write_reg(REG_REF2_ETA, APB_DW'(e2));
        write_reg(REG_REF2_PHI, APB_DW'(p2));
        write_reg(REG_REF3_ETA, APB_DW'(e3));
        write_reg(REG_REF3_PHI, APB_DW'(p3));
        write_reg(REG_REF3_EN, APB_DW'(en));
        write_reg(REG_MAX_DIST, APB_DW'(lim));
        clear_event();
    endtask

    task automatic load_random_refs(input bit en, input t_dist lim);
        load_config(rand_between(-ETA_LIM, ETA_LIM), rand_between(-PHI_LIM, PHI_LIM),
                    rand_between(-ETA_LIM, ETA_LIM), rand_between(-PHI_LIM, PHI_LIM),
                    rand_between(-ETA_LIM, ETA_LIM), rand_between(-PHI_LIM, PHI_LIM),
                    en, lim);
    endtask

    task automatic queue_jet(input int eta, input int phi, input bit last, input bit hold);
        t_jet_item item;
        item.eta      = t_eta'(eta);
        item.phi      = t_phi'(phi);
        item.last_jet = last;
        item.hold     = hold;
        pending_jets = {pending_jets, item};
        jets_outstanding++;
        if (last) events_queued++;
    endtask

    // Mostly cluster jets around the references so the nearest-jet race is contested.
    task automatic random_jet_position(output int eta, output int phi);
        int pick;
        int spread;
        int r;
        pick = $urandom_range(0, 19);
        if (pick < 13) begin
            r      = pick % NUM_REFS;
            spread = (pick < 5) ? 2 : (pick < 10) ? 24 : 160;
            eta    = clamp(int'(ref_eta_cfg[r]) + rand_between(-spread, spread), ETA_LIM);
            phi    = clamp(int'(ref_phi_cfg[r]) + rand_between(-spread, spread), PHI_LIM);
        end else if (pick < 19) begin
            eta = rand_between(-ETA_LIM, ETA_LIM);
            phi = rand_between(-PHI_LIM, PHI_LIM);
        end else begin
            // any bit pattern of the fields
            eta = $urandom;
            phi = $urandom;
        end
    endtask

    task automatic queue_random_phase(input int n_items);
        int  queued;
        int  len;
        int  pick;
        int  eta;
        int  phi;
        bit  held;
        queued = 0;
        held   = 1'b0;
        while (queued < n_items) begin
            pick = $urandom_range(0, 19);
            len  = (pick < 14) ? rand_between(1, 4) :
                   (pick < 19) ? rand_between(5, 12) : rand_between(13, 40);
            for (int k = 0; k < len; k++) begin
                random_jet_position(eta, phi);
                // hold one event back until the block has drained
                queue_jet(eta, phi, k == len - 1, k == 0 && !held && queued >= n_items / 2);
            end
            if (!held && queued >= n_items / 2) held = 1'b1;
            queued += len;
        end
    endtask

    task automatic wait_idle();
        while (jets_outstanding != 0 || expected_matches.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("nearest_jet_delta_r_matcher_unit_tb NOT OK");
            $finish;
        end
    end

    // jet driver
    always @(posedge i_clk) begin
        t_jet_item item;
        logic      send;
        if (!i_rst_n) begin
            jet_if.valid    <= 1'b0;
            jet_if.jet_eta  <= '0;
            jet_if.jet_phi  <= '0;
            jet_if.last_jet <= 1'b0;
        end else begin
            if (jet_if.valid && jet_if.ready) begin
                predict_matches(current_jet);
                jets_outstanding--;
                jets_accepted++;
            end
            if (!jet_if.valid || jet_if.ready) begin
                send = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_jets.size() != 0 &&
                             !(pending_jets[0].hold && expected_matches.size() != 0)) begin
                    item        = pending_jets.pop_front();
                    current_jet = item;
                    send        = 1'b1;
                    jet_if.jet_eta  <= item.eta;
                    jet_if.jet_phi  <= item.phi;
                    jet_if.last_jet <= item.last_jet;
                    if (sender_bursty) begin
                        burst_left--;
                        if (burst_left <= 0) begin
                            burst_left = $urandom_range(1, 24);
                            gap_left   = $urandom_range(1, SEND_GAP_MAX);
                        end
                    end
                end
                jet_if.valid <= send;
            end
        end
    end

    // result receiver backpressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else if (!receiver_stalls) begin
            res_if.ready <= 1'b1;
        end else if (ready_run > 0) begin
            ready_run--;
            res_if.ready <= 1'b1;
        end else if (stall_run > 0) begin
            stall_run--;
            res_if.ready <= 1'b0;
        end else begin
            ready_run = $urandom_range(0, 10);
            stall_run = $urandom_range(1, STALL_MAX);
            res_if.ready <= 1'b1;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_match_res want;
        if (i_rst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            if (expected_matches.size() == 0) begin
                mismatches++;
                $error("unexpected result transaction for reference %0d",
                       res_if.reference_number);
            end else begin
                want = expected_matches.pop_front();
                results_checked++;
                check_field("reference_number", DIST_W'(want.ref_num),
                            DIST_W'(res_if.reference_number));
                check_field("matched", DIST_W'(want.matched), DIST_W'(res_if.matched));
                check_field("jet_position", DIST_W'(want.pos), DIST_W'(res_if.jet_position));
                check_field("distance_sq", want.distance, res_if.distance_sq);
                check_field("last_result", DIST_W'(want.last_res),
                            DIST_W'(res_if.last_result));
            end
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        sender_bursty   = 1'b1;
        receiver_stalls = 1'b1;
        burst_left      = 4;
        for (int r = 0; r < NUM_REFS; r++) begin
            ref_eta_cfg[r] = '0;
            ref_phi_cfg[r] = '0;
        end
        ref3_en_cfg = 1'b0;
        limit_cfg   = LIMIT_RESET;
        clear_event();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset configuration: all references at the origin, third one off
        queue_jet(0, 0, 1'b1, 1'b0);
        queue_jet(ETA_LIM, PHI_LIM, 1'b0, 1'b0);
        queue_jet(-ETA_LIM, -PHI_LIM, 1'b0, 1'b0);
        queue_jet(3, 4, 1'b1, 1'b0);
        // equal distances: keep the earliest jet
        queue_jet(10, 0, 1'b0, 1'b0);
        queue_jet(0, -10, 1'b0, 1'b0);
        queue_jet(-10, 0, 1'b1, 1'b0);
        queue_jet(ETA_LIM, -PHI_LIM, 1'b1, 1'b0);
        wait_idle();

        // limit of one: only exact hits match
        load_config(ETA_LIM, PHI_LIM, -ETA_LIM, -PHI_LIM, 0, 0, 1'b1, 1);
        queue_jet(ETA_LIM, PHI_LIM, 1'b0, 1'b0);
        queue_jet(-ETA_LIM, -PHI_LIM, 1'b0, 1'b0);
        queue_jet(1, 0, 1'b0, 1'b0);
        queue_jet(0, 0, 1'b1, 1'b0);
        queue_jet(2047, 1023, 1'b0, 1'b0);
        queue_jet(-2048, -1024, 1'b1, 1'b0);
        wait_idle();

        // zero limit: nothing can match
        write_reg(REG_MAX_DIST, APB_DW'(0));
        clear_event();
        queue_jet(ETA_LIM, PHI_LIM, 1'b0, 1'b0);
        queue_jet(0, 0, 1'b1, 1'b0);
        wait_idle();

        load_random_refs(1'b1, LIMIT_RESET);
        queue_random_phase(PHASE_ITEMS);
        wait_idle();

        sender_bursty   = 1'b0;
        receiver_stalls = 1'b0;
        load_random_refs(1'b0, t_dist'($urandom_range(1, 20000)));
        queue_random_phase(PHASE_ITEMS);
        wait_idle();

        receiver_stalls = 1'b1;
        load_config(ETA_LIM, PHI_LIM, -ETA_LIM, -PHI_LIM, -ETA_LIM, PHI_LIM, 1'b1,
                    LIMIT_RESET);
        queue_random_phase(PHASE_ITEMS);
        wait_idle();

        sender_bursty = 1'b1;
        load_random_refs(1'b1, 1);
        queue_random_phase(PHASE_ITEMS);
        wait_idle();

        load_random_refs(1'b1, t_dist'($urandom_range(1, LIMIT_RESET)));
        queue_random_phase(PHASE_ITEMS);
        wait_idle();

        load_random_refs($urandom_range(0, 1) != 0, {DIST_W{1'b1}});
        queue_random_phase(PHASE_ITEMS);
        wait_idle();

        $display("Checked %0d results from %0d events (%0d jets), %0d register writes.",
                 results_checked, events_queued, jets_accepted, reg_writes);
        $display("Covered reset defaults, ties, exact-hit and zero limits, a disabled third");
        $display("reference and backpressure on both sides with a full drain pause.");
        if (mismatches == 0) begin
            $display("nearest_jet_delta_r_matcher_unit_tb OK");
        end else begin
            $display("nearest_jet_delta_r_matcher_unit_tb NOT OK");
        end
        $finish;
    end

endmodule
